// File: rtl/fwpe_pkg.sv
`default_nettype none

package fwpe_pkg;

    localparam int ACTION_BITS = 2;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_ENQ      = 2'd0,
        ACT_DEQ_HEAD = 2'd1,
        ACT_DEQ_MAX  = 2'd2
    } t_action;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: rtl/fwpe_cell.sv
`default_nettype none

module fwpe_cell import fwpe_pkg::*; #(
    parameter int INDEX         = 0,
    parameter int DEPTH         = 16,
    parameter int TAG_BITS      = 16,
    parameter int PRIORITY_BITS = 8,
    localparam int IW           = $clog2(DEPTH),
    localparam int CW           = $clog2(DEPTH + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cell_ctl                i_ctl,
    input  wire logic [IW-1:0]            i_shift_idx,
    input  wire logic [CW-1:0]            i_count,
    input  wire logic [TAG_BITS-1:0]      i_wr_tag,
    input  wire logic [PRIORITY_BITS-1:0] i_wr_prio,
    input  wire logic [TAG_BITS-1:0]      i_nb_tag,
    input  wire logic [PRIORITY_BITS-1:0] i_nb_prio,
    output logic [TAG_BITS-1:0]           o_tag,
    output logic [PRIORITY_BITS-1:0]      o_prio,
    input  wire logic                     i_tok,
    input  wire logic [TAG_BITS-1:0]      i_best_tag,
    input  wire logic [PRIORITY_BITS-1:0] i_best_prio,
    input  wire logic [IW-1:0]            i_best_idx,
    output logic                          o_tok,
    output logic [TAG_BITS-1:0]           o_best_tag,
    output logic [PRIORITY_BITS-1:0]      o_best_prio,
    output logic [IW-1:0]                 o_best_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
    localparam logic [CW-1:0] MY_POS = CW'(INDEX);

    logic [TAG_BITS-1:0]      r_tag, n_tag;
    logic [PRIORITY_BITS-1:0] r_prio, n_prio;
    logic                     r_tok;
    logic [TAG_BITS-1:0]      r_best_tag, n_best_tag;
    logic [PRIORITY_BITS-1:0] r_best_prio, n_best_prio;
    logic [IW-1:0]            r_best_idx, n_best_idx;
    logic                     w_valid;
    logic                     w_take;

    assign w_valid = MY_POS < i_count;
    assign w_take  = w_valid && ((INDEX == 0) || (r_prio > i_best_prio));

    always_comb begin
        n_tag  = r_tag;
        n_prio = r_prio;
        if (i_ctl.load && (MY_POS == i_count)) begin
            n_tag  = i_wr_tag;
            n_prio = i_wr_prio;
        end else if (i_ctl.shift && (MY_IDX >= i_shift_idx)) begin
            n_tag  = i_nb_tag;
            n_prio = i_nb_prio;
        end
        if (w_take) begin
            n_best_tag  = r_tag;
            n_best_prio = r_prio;
            n_best_idx  = MY_IDX;
        end else begin
            n_best_tag  = i_best_tag;
            n_best_prio = i_best_prio;
            n_best_idx  = i_best_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag       <= n_tag;
        r_prio      <= n_prio;
        r_best_tag  <= n_best_tag;
        r_best_prio <= n_best_prio;
        r_best_idx  <= n_best_idx;
    end

    assign o_tag       = r_tag;
    assign o_prio      = r_prio;
    assign o_tok       = r_tok;
    assign o_best_tag  = r_best_tag;
    assign o_best_prio = r_best_prio;
    assign o_best_idx  = r_best_idx;

endmodule

`default_nettype wire

// File: rtl/fifo_with_priority_extract_top.sv
// Ordered queue of up to DEPTH entries (tag, priority) with head and
// highest-priority removal.
// Input stream: tuser carries the action (enqueue, remove head, remove
// highest priority); tdata carries tag and priority of an enqueued entry.
// Output stream: one word per input word with got_item, tag, priority,
// dropped and the entry count after the step.
// Entries sit in a row of cells; cell 0 is the head. A removal closes the
// gap by moving every later cell one place toward the head.
// Enqueue, head removal, the unused action and a highest-priority removal
// from an empty queue: the result word is valid in the cycle after acceptance.
// Highest-priority removal from a non-empty queue: a search token walks the
// whole row one cell per cycle carrying the best entry so far; when it leaves
// the last cell, that entry is removed and the result word is registered.
// One word is in flight at a time; the next input word is accepted no earlier
// than the edge at which the result word leaves.
// A stalled receiver holds the result in the output register and blocks new
// input words until it is taken.
// Reset empties the queue and the output register; no clearing pass.
`default_nettype none

module fifo_with_priority_extract_top import fwpe_pkg::*; #(
    parameter int DEPTH         = 16,
    parameter int TAG_BITS      = 16,
    parameter int PRIORITY_BITS = 8,
    localparam int IW           = $clog2(DEPTH),
    localparam int CW           = $clog2(DEPTH + 1),
    localparam int IN_BITS      = TAG_BITS + PRIORITY_BITS,
    localparam int IN_W         = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS     = 2 + TAG_BITS + PRIORITY_BITS + CW,
    localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // item_tag, item_priority
    input  wire logic [IN_W-1:0]        i_s_axis_tdata,
    // action
    input  wire logic [ACTION_BITS-1:0] i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // got_item, out_tag, out_priority, dropped, entry_count
    output logic [OUT_W-1:0]            o_m_axis_tdata
);

    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [TAG_BITS-1:0]      w_tag [DEPTH];
    logic [PRIORITY_BITS-1:0] w_prio [DEPTH];
    logic                     w_tok [DEPTH+1];
    logic [TAG_BITS-1:0]      w_best_tag [DEPTH+1];
    logic [PRIORITY_BITS-1:0] w_best_prio [DEPTH+1];
    logic [IW-1:0]            w_best_idx [DEPTH+1];

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_out_valid, n_out_valid;
    logic                     r_out_got, n_out_got;
    logic [TAG_BITS-1:0]      r_out_tag, n_out_tag;
    logic [PRIORITY_BITS-1:0] r_out_prio, n_out_prio;
    logic                     r_out_drop, n_out_drop;
    logic [CW-1:0]            r_out_count, n_out_count;

    t_cell_ctl                w_ctl;
    logic [IW-1:0]            w_shift_idx;
    logic [TAG_BITS-1:0]      w_in_tag;
    logic [PRIORITY_BITS-1:0] w_in_prio;
    t_action                  w_act;
    logic                     w_out_free;
    logic                     w_accept;
    logic                     w_tok_start;
    logic                     w_res;
    logic                     w_res_got;
    logic [TAG_BITS-1:0]      w_res_tag;
    logic [PRIORITY_BITS-1:0] w_res_prio;
    logic                     w_res_drop;

    assign w_in_tag        = i_s_axis_tdata[TAG_BITS-1:0];
    assign w_in_prio       = i_s_axis_tdata[IN_BITS-1:TAG_BITS];
    assign w_act           = t_action'(i_s_axis_tuser);
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_tok[0]       = w_tok_start;
    assign w_best_tag[0]  = '0;
    assign w_best_prio[0] = '0;
    assign w_best_idx[0]  = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [TAG_BITS-1:0]      w_nb_tag;
        logic [PRIORITY_BITS-1:0] w_nb_prio;
        if (g == DEPTH - 1) begin : g_last
            assign w_nb_tag  = '0;
            assign w_nb_prio = '0;
        end else begin : g_mid
            assign w_nb_tag  = w_tag[g+1];
            assign w_nb_prio = w_prio[g+1];
        end
        fwpe_cell #(
            .INDEX         (g),
            .DEPTH         (DEPTH),
            .TAG_BITS      (TAG_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_shift_idx (w_shift_idx),
            .i_count     (r_count),
            .i_wr_tag    (w_in_tag),
            .i_wr_prio   (w_in_prio),
            .i_nb_tag    (w_nb_tag),
            .i_nb_prio   (w_nb_prio),
            .o_tag       (w_tag[g]),
            .o_prio      (w_prio[g]),
            .i_tok       (w_tok[g]),
            .i_best_tag  (w_best_tag[g]),
            .i_best_prio (w_best_prio[g]),
            .i_best_idx  (w_best_idx[g]),
            .o_tok       (w_tok[g+1]),
            .o_best_tag  (w_best_tag[g+1]),
            .o_best_prio (w_best_prio[g+1]),
            .o_best_idx  (w_best_idx[g+1])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_got   = r_out_got;
        n_out_tag   = r_out_tag;
        n_out_prio  = r_out_prio;
        n_out_drop  = r_out_drop;
        n_out_count = r_out_count;
        w_ctl       = '0;
        w_shift_idx = '0;
        w_tok_start = 1'b0;
        w_res       = 1'b0;
        w_res_got   = 1'b0;
        w_res_tag   = '0;
        w_res_prio  = '0;
        w_res_drop  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_act)
                        ACT_ENQ: begin
                            w_res = 1'b1;
                            if (r_count == FULL) begin
                                w_res_drop = 1'b1;
                            end else begin
                                w_ctl.load = 1'b1;
                                n_count    = r_count + CW'(1);
                            end
                        end
                        ACT_DEQ_HEAD: begin
                            w_res = 1'b1;
                            if (r_count != '0) begin
                                w_ctl.shift = 1'b1;
                                w_res_got   = 1'b1;
                                w_res_tag   = w_tag[0];
                                w_res_prio  = w_prio[0];
                                n_count     = r_count - CW'(1);
                            end
                        end
                        ACT_DEQ_MAX: begin
                            if (r_count != '0) begin
                                w_tok_start = 1'b1;
                                n_state     = ST_SEARCH;
                            end else begin
                                w_res = 1'b1;
                            end
                        end
                        default: begin
                            w_res = 1'b1;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (w_tok[DEPTH]) begin
                    w_ctl.shift = 1'b1;
                    w_shift_idx = w_best_idx[DEPTH];
                    w_res       = 1'b1;
                    w_res_got   = 1'b1;
                    w_res_tag   = w_best_tag[DEPTH];
                    w_res_prio  = w_best_prio[DEPTH];
                    n_count     = r_count - CW'(1);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (w_res) begin
            n_out_valid = 1'b1;
            n_out_got   = w_res_got;
            n_out_tag   = w_res_tag;
            n_out_prio  = w_res_prio;
            n_out_drop  = w_res_drop;
            n_out_count = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_got   <= n_out_got;
        r_out_tag   <= n_out_tag;
        r_out_prio  <= n_out_prio;
        r_out_drop  <= n_out_drop;
        r_out_count <= n_out_count;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_count, r_out_drop, r_out_prio, r_out_tag,
                                     r_out_got});

endmodule

`default_nettype wire

// File: tb/fifo_with_priority_extract_top_tb.sv
`default_nettype none

module fifo_with_priority_extract_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fwpe_pkg::*;

    localparam int DEPTH        = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 600;
    localparam int LONG_HOLD    = 300;
    localparam logic [ACTION_BITS-1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic [15:0] tag;
        logic [7:0]  prio;
    } t_entry;

    typedef struct packed {
        logic [4:0]  count;
        logic        dropped;
        logic [7:0]  prio;
        logic [15:0] tag;
        logic        got;
    } t_result;

    typedef struct {
        logic [ACTION_BITS-1:0] act;
        logic [15:0]            tag;
        logic [7:0]             prio;
        int                     reps;
        bit                     typed;
        t_result                want;
    } t_stim_row;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [23:0]            s_tdata  = '0;
    logic [ACTION_BITS-1:0] s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [31:0]            m_tdata;

    t_entry    held_entries[$];
    t_result   pending_results[$];
    t_stim_row dir_rows[$];
    int        mismatches    = 0;
    int        cycle_count   = 0;
    int        results_taken = 0;
    bit        quiet_sender  = 1'b0;

    initial begin
        forever #6 clk = ~clk;
    end

    fifo_with_priority_extract_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_result res(bit got, logic [15:0] tag, logic [7:0] prio, bit drop,
                                    int cnt);
        t_result r;
        r.got     = got;
        r.tag     = tag;
        r.prio    = prio;
        r.dropped = drop;
        r.count   = 5'(cnt);
        return r;
    endfunction

    function automatic t_result queue_step(logic [ACTION_BITS-1:0] act, logic [15:0] tag,
                                           logic [7:0] prio);
        t_result r;
        int      best;
        r = '0;
        case (act)
            ACT_ENQ: begin
                if (held_entries.size() >= DEPTH) begin
                    r.dropped = 1'b1;
                end else begin
                    held_entries.push_back(t_entry'{tag, prio});
                end
            end
            ACT_DEQ_HEAD: begin
                if (held_entries.size() > 0) begin
                    r.got  = 1'b1;
                    r.tag  = held_entries[0].tag;
                    r.prio = held_entries[0].prio;
                    void'(held_entries.pop_front());
                end
            end
            ACT_DEQ_MAX: begin
                if (held_entries.size() > 0) begin
                    best = 0;
                    for (int i = 1; i < held_entries.size(); i++) begin
                        if (held_entries[i].prio > held_entries[best].prio) begin
                            best = i;
                        end
                    end
                    r.got  = 1'b1;
                    r.tag  = held_entries[best].tag;
                    r.prio = held_entries[best].prio;
                    held_entries.delete(best);
                end
            end
            default: begin
            end
        endcase
        r.count = 5'(held_entries.size());
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] seen);
        mismatches++;
        $display("mismatch on %s: expected %0h, got %0h (cycle %0d)", field, want, seen,
                 cycle_count);
    endtask

    task automatic check_word(t_result seen);
        t_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected word", 32'(0), 32'(seen));
        end else begin
            want = pending_results.pop_front();
            if (seen.got !== want.got) begin
                report_mismatch("got_item", 32'(want.got), 32'(seen.got));
            end
            if (seen.tag !== want.tag) begin
                report_mismatch("out_tag", 32'(want.tag), 32'(seen.tag));
            end
            if (seen.prio !== want.prio) begin
                report_mismatch("out_priority", 32'(want.prio), 32'(seen.prio));
            end
            if (seen.dropped !== want.dropped) begin
                report_mismatch("dropped", 32'(want.dropped), 32'(seen.dropped));
            end
            if (seen.count !== want.count) begin
                report_mismatch("entry_count", 32'(want.count), 32'(seen.count));
            end
        end
    endtask

    task automatic add_row(logic [ACTION_BITS-1:0] act, logic [15:0] tag, logic [7:0] prio,
                           int reps, bit typed, t_result want);
        t_stim_row row;
        row.act   = act;
        row.tag   = tag;
        row.prio  = prio;
        row.reps  = reps;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    task automatic send_word(logic [ACTION_BITS-1:0] act, logic [15:0] tag, logic [7:0] prio,
                             bit typed, t_result want);
        int      gap;
        t_result r;
        gap = quiet_sender ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {prio, tag};
        do @(posedge clk); while (!(s_tvalid && s_tready));
        r = queue_step(act, tag, prio);
        pending_results.push_back(typed ? want : r);
    endtask

    task automatic release_sender();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_drain();
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // receiver: random stalls, quiet stretches, and two long holds
    initial begin
        int stall_left;
        bit quiet;
        stall_left = 0;
        quiet      = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                check_word(t_result'(m_tdata[30:0]));
                results_taken++;
                if (results_taken % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
                if (results_taken == 150 || results_taken == 420) begin
                    stall_left = LONG_HOLD;
                end else begin
                    stall_left = quiet ? 0 : $urandom_range(0, 17);
                end
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [ACTION_BITS-1:0] act;
        logic [7:0]             prio;
        int                     sent;
        int                     chunk_left;
        int                     mode;
        int                     enq_pct;
        int                     pick;
        bit                     narrow;
        bit                     paused;

        add_row(ACT_DEQ_HEAD, 16'h0000, 8'h00, 1, 1'b1, res(0, 0, 0, 0, 0));
        add_row(ACT_DEQ_MAX, 16'hFFFF, 8'hFF, 1, 1'b1, res(0, 0, 0, 0, 0));
        add_row(ACT_NONE, 16'hFFFF, 8'hFF, 1, 1'b1, res(0, 0, 0, 0, 0));
        add_row(ACT_ENQ, 16'hFFFF, 8'hFF, 1, 1'b1, res(0, 0, 0, 0, 1));
        add_row(ACT_ENQ, 16'h0000, 8'h00, 1, 1'b0, '0);
        add_row(ACT_ENQ, 16'h1234, 8'hFF, 1, 1'b0, '0);
        add_row(ACT_ENQ, 16'h8000, 8'h80, 13, 1'b0, '0);
        add_row(ACT_ENQ, 16'hAAAA, 8'h55, 1, 1'b1, res(0, 0, 0, 1, 16));
        add_row(ACT_NONE, 16'h5555, 8'hAA, 1, 1'b1, res(0, 0, 0, 0, 16));
        add_row(ACT_DEQ_MAX, 16'h0000, 8'h00, 1, 1'b1, res(1, 16'hFFFF, 8'hFF, 0, 15));
        add_row(ACT_DEQ_MAX, 16'h0000, 8'h00, 1, 1'b0, '0);
        add_row(ACT_DEQ_HEAD, 16'h0000, 8'h00, 1, 1'b0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            for (int k = 0; k < dir_rows[i].reps; k++) begin
                send_word(dir_rows[i].act, dir_rows[i].tag + 16'(k), dir_rows[i].prio ^ 8'(k),
                          dir_rows[i].typed, dir_rows[i].want);
            end
        end
        release_sender();
        wait_for_drain();

        sent       = 0;
        chunk_left = 0;
        mode       = 0;
        narrow     = 1'b0;
        paused     = 1'b0;
        while (sent < RANDOM_WORDS) begin
            if (chunk_left == 0) begin
                chunk_left   = $urandom_range(8, 40);
                mode         = $urandom_range(0, 2);
                narrow       = ($urandom_range(0, 1) == 1);
                quiet_sender = ($urandom_range(0, 3) == 0);
                if ((sent > 0 && $urandom_range(0, 5) == 0) || (sent >= 300 && !paused)) begin
                    paused = 1'b1;
                    release_sender();
                    wait_for_drain();
                end
            end
            enq_pct = (mode == 0) ? 75 : (mode == 1) ? 20 : 45;
            pick    = $urandom_range(0, 99);
            if (pick < 4) begin
                act = ACT_NONE;
            end else if (pick < 4 + enq_pct) begin
                act = ACT_ENQ;
            end else if ($urandom_range(0, 4) < 2) begin
                act = ACT_DEQ_HEAD;
            end else begin
                act = ACT_DEQ_MAX;
            end
            if (narrow) begin
                prio = 8'($urandom_range(0, 3)) ^ ($urandom_range(0, 1) ? 8'hFC : 8'h00);
            end else begin
                prio = 8'($urandom_range(0, 255));
            end
            send_word(act, 16'($urandom_range(0, 65535)), prio, 1'b0, '0);
            sent++;
            chunk_left--;
        end

        release_sender();
        wait_for_drain();
        repeat (24) @(posedge clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
